/* hw/rtl/midi_last_note_priority_voice_assert.svh */
// Assertion macros used by the checker file of the MIDI voice block.
`ifndef MIDI_LAST_NOTE_PRIORITY_VOICE_ASSERT_SVH
`define MIDI_LAST_NOTE_PRIORITY_VOICE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define MLNP_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MLNP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MLNP_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/midi_lnp_pkg.sv */
// Shared constants, types and the pitch-class tone function of the MIDI voice block.
`default_nettype none

package midi_lnp_pkg;

   // Sizes of the note store and of the stamps.
   localparam int NOTE_COUNT  = 128;
   localparam int STAMP_BITS  = 8;
   localparam int NOTE_BITS   = 7;
   localparam int IDX_BITS    = $clog2(NOTE_COUNT);
   localparam int BYTE_BITS   = 8;
   localparam int DAC_BITS    = 12;

   // Depth of the message queue between parser and scanner.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Status byte codes.
   localparam logic [BYTE_BITS-1:0] STATUS_MASK = 8'hF0;
   localparam logic [BYTE_BITS-1:0] STATUS_ON   = 8'h90;
   localparam logic [BYTE_BITS-1:0] STATUS_OFF  = 8'h80;

   // One parsed note message.
   typedef struct packed {
      logic                 is_on;
      logic [NOTE_BITS-1:0] note;
   } msg_type;

   // Tone level of a note's pitch class. The note is split by twelve with a
   // reciprocal multiply (43/512), which is exact for all 7-bit note numbers.
   function automatic logic [DAC_BITS-1:0] note_tone(input logic [NOTE_BITS-1:0] note);
      logic [NOTE_BITS+5:0] prod;
      logic [3:0]           quot;
      logic [NOTE_BITS-1:0] twelve_q;
      logic [NOTE_BITS-1:0] rem;
      logic [DAC_BITS-1:0]  tone;
      prod     = {6'd0, note} * 13'd43;
      quot     = prod[12:9];
      twelve_q = NOTE_BITS'(quot) * NOTE_BITS'(12);
      rem      = note - twelve_q;
      case (rem[3:0])
         4'd0:    tone = 12'd1508;
         4'd1:    tone = 12'd1587;
         4'd2:    tone = 12'd1666;
         4'd3:    tone = 12'd1745;
         4'd4:    tone = 12'd1824;
         4'd5:    tone = 12'd1903;
         4'd6:    tone = 12'd1986;
         4'd7:    tone = 12'd2065;
         4'd8:    tone = 12'd2146;
         4'd9:    tone = 12'd2225;
         4'd10:   tone = 12'd2304;
         default: tone = 12'd2383;
      endcase
      return tone;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/midi_lnp_front.sv */
// Byte parser: recognizes note on and note off messages and hands them to the queue.
`default_nettype none

module midi_lnp_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [midi_lnp_pkg::BYTE_BITS-1:0]   req_rx_byte,
   input  wire logic                                 q_full,
   output logic                                      msg_push,
   output midi_lnp_pkg::msg_type                     msg
);

   typedef enum logic [1:0] {
      PH_STATUS,
      PH_NOTE,
      PH_VEL
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic                               pending_is_on_ff, pending_is_on_in;
   logic [midi_lnp_pkg::NOTE_BITS-1:0] pending_note_ff, pending_note_in;
   logic                               accept;
   logic [midi_lnp_pkg::BYTE_BITS-1:0] status_hi;

   // Bytes are held off only while the queue has no room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign status_hi = req_rx_byte & midi_lnp_pkg::STATUS_MASK;

   // The velocity byte completes a message and pushes it.
   assign msg_push  = accept && (phase_ff == PH_VEL);
   assign msg.is_on = pending_is_on_ff;
   assign msg.note  = pending_note_ff;

   // Next parse state for each accepted transaction.
   always_comb begin
      phase_in         = phase_ff;
      pending_is_on_in = pending_is_on_ff;
      pending_note_in  = pending_note_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_STATUS: begin
               if (status_hi == midi_lnp_pkg::STATUS_ON ||
                   status_hi == midi_lnp_pkg::STATUS_OFF) begin
                  pending_is_on_in = (status_hi == midi_lnp_pkg::STATUS_ON);
                  phase_in         = PH_NOTE;
               end else begin
                  phase_in = PH_STATUS;
               end
            end
            PH_NOTE: begin
               pending_note_in = req_rx_byte[midi_lnp_pkg::NOTE_BITS-1:0];
               phase_in        = PH_VEL;
            end
            PH_VEL: begin
               phase_in = PH_STATUS;
            end
            default: begin
               phase_in = PH_STATUS;
            end
         endcase
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STATUS;
         pending_is_on_ff <= 1'b0;
         pending_note_ff  <= '0;
      end else begin
         phase_ff         <= phase_in;
         pending_is_on_ff <= pending_is_on_in;
         pending_note_ff  <= pending_note_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/midi_lnp_queue.sv */
// Short message queue between the parser and the scanner.
`default_nettype none

module midi_lnp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire midi_lnp_pkg::msg_type push_msg,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       avail,
   output midi_lnp_pkg::msg_type      pop_msg
);

   localparam logic [midi_lnp_pkg::QPTR_BITS:0] DEPTH_CNT =
      (midi_lnp_pkg::QPTR_BITS+1)'(midi_lnp_pkg::QUEUE_DEPTH);
   localparam logic [midi_lnp_pkg::QPTR_BITS-1:0] LAST_PTR =
      midi_lnp_pkg::QPTR_BITS'(midi_lnp_pkg::QUEUE_DEPTH - 1);

   midi_lnp_pkg::msg_type              entry_ff [midi_lnp_pkg::QUEUE_DEPTH];
   logic [midi_lnp_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [midi_lnp_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [midi_lnp_pkg::QPTR_BITS:0]   count_ff, count_in;
   logic                               do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign avail   = (count_ff != '0);
   assign pop_msg = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && avail;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_msg;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/midi_lnp_back.sv */
// Stamp store and scanner: applies each note message, finds the newest note, reports it.
`default_nettype none

module midi_lnp_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_avail,
   input  wire midi_lnp_pkg::msg_type               q_msg,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [midi_lnp_pkg::DAC_BITS-1:0]        rsp_dac_value,
   output logic                                     rsp_gate,
   output logic [midi_lnp_pkg::NOTE_BITS-1:0]       rsp_lead_note
);

   localparam int IDX_BITS   = midi_lnp_pkg::IDX_BITS;
   localparam int STAMP_BITS = midi_lnp_pkg::STAMP_BITS;
   localparam int NOTE_BITS  = midi_lnp_pkg::NOTE_BITS;
   localparam int DAC_BITS   = midi_lnp_pkg::DAC_BITS;
   localparam int NOTE_COUNT = midi_lnp_pkg::NOTE_COUNT;
   localparam logic [IDX_BITS-1:0]  LAST_IDX   = IDX_BITS'(NOTE_COUNT - 1);
   localparam logic [NOTE_BITS:0]   NOTE_LIMIT = (NOTE_BITS+1)'(NOTE_COUNT);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_REPORT
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [STAMP_BITS-1:0]   stamp_ctr_ff, stamp_ctr_in;
   logic [NOTE_COUNT-1:0]   stamp_vld_ff, stamp_vld_in;
   logic [IDX_BITS-1:0]     scan_addr_ff, scan_addr_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                    rd_vbit_ff, rd_vbit_in;
   logic [STAMP_BITS-1:0]   rd_data_ff;
   logic [STAMP_BITS-1:0]   best_stamp_ff, best_stamp_in;
   logic [IDX_BITS-1:0]     best_idx_ff, best_idx_in;
   logic [DAC_BITS-1:0]     held_dac_ff, held_dac_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DAC_BITS-1:0]     rsp_dac_ff, rsp_dac_in;
   logic                    rsp_gate_ff, rsp_gate_in;
   logic [NOTE_BITS-1:0]    rsp_note_ff, rsp_note_in;

   logic [STAMP_BITS-1:0]   stamp_mem [NOTE_COUNT];
   logic                    mem_we;
   logic [IDX_BITS-1:0]     mem_waddr;
   logic [STAMP_BITS-1:0]   eff_stamp;
   logic                    in_range;
   logic                    found;
   logic [DAC_BITS-1:0]     tone;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = rsp_dac_ff;
   assign rsp_gate      = rsp_gate_ff;
   assign rsp_lead_note = rsp_note_ff;

   assign mem_waddr = q_msg.note[IDX_BITS-1:0];
   assign in_range  = ({1'b0, q_msg.note} < NOTE_LIMIT);
   // An entry never written since reset reads as stamp zero.
   assign eff_stamp = rd_vbit_ff ? rd_data_ff : '0;
   assign found     = (best_stamp_ff != '0);
   assign tone      = midi_lnp_pkg::note_tone(NOTE_BITS'(best_idx_ff));

   // Control: apply a message, sweep the store one entry a cycle, report.
   always_comb begin
      state_in      = state_ff;
      stamp_ctr_in  = stamp_ctr_ff;
      stamp_vld_in  = stamp_vld_ff;
      scan_addr_in  = scan_addr_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      held_dac_in   = held_dac_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dac_in    = rsp_dac_ff;
      rsp_gate_in   = rsp_gate_ff;
      rsp_note_in   = rsp_note_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;

      // Read pipeline registers the scan address and follows it in the next cycle.
      rd_pend_in = (state_ff == BK_SCAN);
      rd_idx_in  = scan_addr_ff;
      rd_vbit_in = stamp_vld_ff[scan_addr_ff];

      // Strictly greater keeps the lowest note among equal stamps.
      if (rd_pend_ff && (eff_stamp > best_stamp_ff)) begin
         best_stamp_in = eff_stamp;
         best_idx_in   = rd_idx_ff;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (q_avail) begin
               q_pop         = 1'b1;
               best_stamp_in = '0;
               best_idx_in   = '0;
               scan_addr_in  = '0;
               state_in      = BK_SCAN;
               if (in_range) begin
                  if (q_msg.is_on) begin
                     mem_we                  = 1'b1;
                     stamp_vld_in[mem_waddr] = 1'b1;
                     stamp_ctr_in            = stamp_ctr_ff + 1'b1;
                  end else begin
                     stamp_vld_in[mem_waddr] = 1'b0;
                  end
               end else if (q_msg.is_on) begin
                  stamp_ctr_in = stamp_ctr_ff + 1'b1;
               end
            end
         end
         BK_SCAN: begin
            if (scan_addr_ff == LAST_IDX) begin
               state_in = BK_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         BK_DRAIN: begin
            state_in = BK_REPORT;
         end
         BK_REPORT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_gate_in  = found;
               if (found) begin
                  held_dac_in = tone;
                  rsp_dac_in  = tone;
                  rsp_note_in = NOTE_BITS'(best_idx_ff);
               end else begin
                  rsp_dac_in  = held_dac_ff;
                  rsp_note_in = '0;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         stamp_ctr_ff  <= STAMP_BITS'(1);
         stamp_vld_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         held_dac_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_dac_ff    <= '0;
         rsp_gate_ff   <= 1'b0;
         rsp_note_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         stamp_ctr_ff  <= stamp_ctr_in;
         stamp_vld_ff  <= stamp_vld_in;
         rd_pend_ff    <= rd_pend_in;
         held_dac_ff   <= held_dac_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_dac_ff    <= rsp_dac_in;
         rsp_gate_ff   <= rsp_gate_in;
         rsp_note_ff   <= rsp_note_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      rd_idx_ff     <= rd_idx_in;
      rd_vbit_ff    <= rd_vbit_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
   end

   // Stamp memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stamp_mem[mem_waddr] <= stamp_ctr_ff;
      end
      rd_data_ff <= stamp_mem[scan_addr_ff];
   end

endmodule

`default_nettype wire

/* hw/rtl/midi_last_note_priority_voice.sv */
// Monophonic MIDI voice with last-note priority: parser, message queue and stamp scanner.
// A byte that does not complete a message is taken when the queue has room, with no result.
// A completed note message is queued, applied to the store, then reported after a full sweep.
// A new message waits until the 128-entry stamp sweep and report of the last one are done.
// The parser takes bytes until two messages wait in the queue, then stalls.
// Synchronous reset clears all stamps at once through per-entry valid bits; no clearing pass.
`default_nettype none

module midi_last_note_priority_voice (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [midi_lnp_pkg::BYTE_BITS-1:0]   req_rx_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [midi_lnp_pkg::DAC_BITS-1:0]         rsp_dac_value,
   output logic                                      rsp_gate,
   output logic [midi_lnp_pkg::NOTE_BITS-1:0]        rsp_lead_note
);

   logic                  msg_push;
   midi_lnp_pkg::msg_type push_msg;
   logic                  q_full;
   logic                  q_avail;
   logic                  q_pop;
   midi_lnp_pkg::msg_type pop_msg;

   midi_lnp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .msg_push    (msg_push),
      .msg         (push_msg)
   );

   midi_lnp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (msg_push),
      .push_msg (push_msg),
      .pop      (q_pop),
      .full     (q_full),
      .avail    (q_avail),
      .pop_msg  (pop_msg)
   );

   midi_lnp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_avail       (q_avail),
      .q_msg         (pop_msg),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dac_value (rsp_dac_value),
      .rsp_gate      (rsp_gate),
      .rsp_lead_note (rsp_lead_note)
   );

endmodule

`default_nettype wire

/* hw/rtl/midi_lnp_checker.sv */
// Port-level checker for the MIDI voice block and its bind to the top level.
`default_nettype none

`include "midi_last_note_priority_voice_assert.svh"

module midi_lnp_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic [midi_lnp_pkg::BYTE_BITS-1:0]  req_rx_byte,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [midi_lnp_pkg::DAC_BITS-1:0]   rsp_dac_value,
   input wire logic                                rsp_gate,
   input wire logic [midi_lnp_pkg::NOTE_BITS-1:0]  rsp_lead_note
);

   // A stalled result transaction keeps its payload.
   `MLNP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_dac_value) && $stable(rsp_gate) && $stable(rsp_lead_note),
      "stalled result changed")

   // Reset leaves no result pending.
   `MLNP_ASSERT_NEXT_RAW(a_reset_idle, reset, !rsp_valid, "result valid after reset")

   // With no note held the note number reads zero.
   `MLNP_ASSERT_IMPLY(a_gate_note, rsp_valid && !rsp_gate, rsp_lead_note == 7'd0,
      "note nonzero with gate low")

   // A held note always shows a tone from the pitch-class table range.
   `MLNP_ASSERT_IMPLY(a_gate_tone, rsp_valid && rsp_gate,
      rsp_dac_value >= 12'd1508 && rsp_dac_value <= 12'd2383, "tone outside table range")

   // An accepted byte is never unknown.
   `MLNP_ASSERT_IMPLY(a_req_known, req_valid && !req_stall, !$isunknown(req_rx_byte),
      "accepted byte unknown")

endmodule

bind midi_last_note_priority_voice midi_lnp_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_rx_byte   (req_rx_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_dac_value (rsp_dac_value),
   .rsp_gate      (rsp_gate),
   .rsp_lead_note (rsp_lead_note)
);

`default_nettype wire

/* verif/tb_midi_last_note_priority_voice.sv */
// Self-checking testbench for the last-note-priority MIDI voice block.
module tb_midi_last_note_priority_voice;
   timeunit 1ns;
   timeprecision 1ps;

   // Sizes and status codes taken from the design package.
   localparam int BYTE_BITS  = midi_lnp_pkg::BYTE_BITS;
   localparam int DAC_BITS   = midi_lnp_pkg::DAC_BITS;
   localparam int NOTE_BITS  = midi_lnp_pkg::NOTE_BITS;
   localparam int STAMP_BITS = midi_lnp_pkg::STAMP_BITS;
   localparam int NOTE_COUNT = midi_lnp_pkg::NOTE_COUNT;
   localparam logic [BYTE_BITS-1:0] STATUS_MASK = midi_lnp_pkg::STATUS_MASK;
   localparam logic [BYTE_BITS-1:0] STATUS_ON   = midi_lnp_pkg::STATUS_ON;
   localparam logic [BYTE_BITS-1:0] STATUS_OFF  = midi_lnp_pkg::STATUS_OFF;

   // Run-length knobs.
   localparam int unsigned BYTE_TARGET   = 1650;
   localparam int unsigned HOLD_CYCLES   = 1500;
   localparam int unsigned HOLD_AFTER    = 40;
   localparam int unsigned TAIL_CYCLES   = 300;
   localparam int unsigned WATCHDOG_IDLE = 20000;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Phases of the MIDI message parser.
   typedef enum logic [1:0] {
      AWAIT_STATUS,
      AWAIT_NOTE,
      AWAIT_VELOCITY
   } parse_phase_type;

   // One voice update as seen on the result channel.
   typedef struct packed {
      logic [DAC_BITS-1:0]  dac_value;
      logic                 gate;
      logic [NOTE_BITS-1:0] lead_note;
   } voice_update_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [BYTE_BITS-1:0]   req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [DAC_BITS-1:0]    rsp_dac_value;
   logic                   rsp_gate;
   logic [NOTE_BITS-1:0]   rsp_lead_note;

   // MIDI bytes waiting to be sent and voice updates waiting to arrive.
   logic [BYTE_BITS-1:0]   midi_bytes_q[$];
   voice_update_type       voice_expect_q[$];

   // Shadow copy of the voice state.
   logic [STAMP_BITS-1:0]  note_stamps[NOTE_COUNT];
   logic [STAMP_BITS-1:0]  stamp_next;
   parse_phase_type        parse_phase;
   logic                   msg_is_on;
   logic [NOTE_BITS-1:0]   msg_note;
   logic [DAC_BITS-1:0]    last_dac;

   int unsigned            err_count = 0;

   midi_last_note_priority_voice DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_dac_value (rsp_dac_value),
      .rsp_gate      (rsp_gate),
      .rsp_lead_note (rsp_lead_note)
   );

   // Clock and the single reset pulse.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Tone level of a pitch class, starting from C.
   function automatic logic [DAC_BITS-1:0] pitch_level(input int unsigned pitch_class);
      case (pitch_class)
         0:       return 12'd1508;
         1:       return 12'd1587;
         2:       return 12'd1666;
         3:       return 12'd1745;
         4:       return 12'd1824;
         5:       return 12'd1903;
         6:       return 12'd1986;
         7:       return 12'd2065;
         8:       return 12'd2146;
         9:       return 12'd2225;
         10:      return 12'd2304;
         default: return 12'd2383;
      endcase
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned random_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 24);
      else
         return $urandom_range(40, 200);
   endfunction

   // Advance the shadow voice by one accepted MIDI byte and queue any update it causes.
   task automatic track_midi_byte(input logic [BYTE_BITS-1:0] rx);
      logic [STAMP_BITS-1:0] best;
      int unsigned           best_idx;
      voice_update_type      upd;
      case (parse_phase)
         AWAIT_NOTE: begin
            msg_note    = rx[NOTE_BITS-1:0];
            parse_phase = AWAIT_VELOCITY;
         end
         AWAIT_VELOCITY: begin
            // The velocity byte completes the message; it is otherwise ignored.
            parse_phase = AWAIT_STATUS;
            if (int'(msg_note) < NOTE_COUNT)
               note_stamps[msg_note] = msg_is_on ? stamp_next : '0;
            if (msg_is_on)
               stamp_next = stamp_next + 1'b1;
            // Highest stamp wins; on a tie the lowest note stays.
            best     = '0;
            best_idx = 0;
            for (int i = 0; i < NOTE_COUNT; i++) begin
               if (note_stamps[i] > best) begin
                  best     = note_stamps[i];
                  best_idx = i;
               end
            end
            if (best != '0)
               last_dac = pitch_level(best_idx % 12);
            upd.dac_value = last_dac;
            upd.gate      = (best != '0);
            upd.lead_note = (best != '0) ? NOTE_BITS'(best_idx) : '0;
            voice_expect_q.push_back(upd);
         end
         default: begin
            // Only note on and note off start a message; anything else is dropped.
            if ((rx & STATUS_MASK) == STATUS_ON || (rx & STATUS_MASK) == STATUS_OFF) begin
               msg_is_on   = ((rx & STATUS_MASK) == STATUS_ON);
               parse_phase = AWAIT_NOTE;
            end else begin
               parse_phase = AWAIT_STATUS;
            end
         end
      endcase
   endtask

   task automatic send_message(input logic [BYTE_BITS-1:0] status,
                               input logic [BYTE_BITS-1:0] note_byte,
                               input logic [BYTE_BITS-1:0] velocity);
      midi_bytes_q.push_back(status);
      midi_bytes_q.push_back(note_byte);
      midi_bytes_q.push_back(velocity);
   endtask

   // Sender: presents queued bytes with random gaps and tracks each accepted transaction.
   int unsigned send_gap  = 0;
   int unsigned send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         send_gap    = 0;
         send_calm   = 0;
         foreach (note_stamps[i])
            note_stamps[i] = '0;
         stamp_next  = STAMP_BITS'(1);
         parse_phase = AWAIT_STATUS;
         msg_is_on   = 1'b0;
         msg_note    = '0;
         last_dac    = '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            track_midi_byte(req_rx_byte);
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (midi_bytes_q.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_rx_byte <= midi_bytes_q.pop_front();
            // Occasional stretches of back-to-back bytes.
            if (send_calm == 0 && $urandom_range(0, 99) < 2)
               send_calm = $urandom_range(30, 80);
            if (send_calm != 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = random_gap();
            end
         end
      end
   end

   // Receiver stall: random gaps, quiet stretches, and one long hold-off that fills the block.
   int unsigned rsp_gap    = 0;
   int unsigned rsp_calm   = 0;
   int unsigned hold_left  = 0;
   bit          hold_done  = 1'b0;
   int unsigned delivered  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            delivered++;
         if (!hold_done && delivered >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_calm == 0 && $urandom_range(0, 99) < 2)
               rsp_calm = $urandom_range(30, 120);
            if (rsp_calm != 0)
               rsp_calm--;
            else
               rsp_gap = random_gap();
         end
      end
   end

   // Monitor: every accepted result transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      voice_update_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (voice_expect_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
               $display("%0t: unexpected result dac=%0d gate=%0d note=%0d", $time,
                        rsp_dac_value, rsp_gate, rsp_lead_note);
         end else begin
            want = voice_expect_q.pop_front();
            if (rsp_dac_value !== want.dac_value || rsp_gate !== want.gate ||
                rsp_lead_note !== want.lead_note) begin
               err_count++;
               if (err_count <= REPORT_LIMIT)
                  $display("%0t: expected dac=%0d gate=%0d note=%0d, got dac=%0d gate=%0d note=%0d",
                           $time, want.dac_value, want.gate, want.lead_note,
                           rsp_dac_value, rsp_gate, rsp_lead_note);
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction is accepted for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_IDLE) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("midi_last_note_priority_voice verification failed");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      int unsigned          counted;
      int unsigned          pick;
      bit                   is_on;
      logic [NOTE_BITS-1:0] note;
      logic [BYTE_BITS-1:0] noise;

      // Note on at the lowest note, then the highest note on a high channel with velocity 0.
      send_message(STATUS_ON, 8'h00, 8'h7F);
      send_message(STATUS_ON | 8'h0F, 8'h7F, 8'h00);
      // Bytes at a message start that are not note on or off are dropped.
      midi_bytes_q.push_back(8'hF8);
      midi_bytes_q.push_back(8'h00);
      midi_bytes_q.push_back(8'hA5);
      // Note off with bit 7 set in the note byte still addresses note 127.
      send_message(STATUS_OFF | 8'h0F, 8'hFF, 8'h40);
      // Releasing the last note clears the gate and holds the tone.
      send_message(STATUS_OFF, 8'h00, 8'h00);
      // Top pitch class with a full-scale velocity byte.
      send_message(STATUS_ON | 8'h0B, 8'h8B, 8'hFF);
      // Status-looking bytes in the data slots are taken as note and velocity.
      send_message(STATUS_ON, STATUS_ON | 8'h05, STATUS_OFF);
      send_message(STATUS_OFF | 8'h0A, 8'h15, 8'h00);
      counted = midi_bytes_q.size();

      // Random part: mostly well-formed note messages, some noise and misaligned bytes.
      while (counted < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            is_on = ($urandom_range(0, 99) < 62);
            if ($urandom_range(0, 99) < 80)
               note = NOTE_BITS'($urandom_range(48, 63));
            else
               note = NOTE_BITS'($urandom_range(0, 127));
            send_message((is_on ? STATUS_ON : STATUS_OFF) | BYTE_BITS'($urandom_range(0, 15)),
                         {1'($urandom_range(0, 1)), note},
                         BYTE_BITS'($urandom_range(0, 255)));
            counted += 3;
         end else if (pick < 92) begin
            do
               noise = BYTE_BITS'($urandom);
            while ((noise & STATUS_MASK) == STATUS_ON || (noise & STATUS_MASK) == STATUS_OFF);
            midi_bytes_q.push_back(noise);
            counted++;
         end else begin
            midi_bytes_q.push_back(BYTE_BITS'($urandom));
            counted++;
         end
      end

      // Wait for every byte to be taken and every update to arrive, then a quiet tail.
      do
         @(negedge clock);
      while (reset || midi_bytes_q.size() != 0 || req_valid);
      while (voice_expect_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (err_count == 0)
         $display("midi_last_note_priority_voice verification clean");
      else
         $display("midi_last_note_priority_voice verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/midi_lnp_pkg.sv
hw/rtl/midi_lnp_front.sv
hw/rtl/midi_lnp_queue.sv
hw/rtl/midi_lnp_back.sv
hw/rtl/midi_last_note_priority_voice.sv
hw/rtl/midi_lnp_checker.sv
verif/tb_midi_last_note_priority_voice.sv
